### rtl/ppm_sum_channel_decoder_top_defines.svh
// Assertion macros shared by the decoder RTL.
// Depends on nothing; included by files that carry concurrent checks.
`ifndef PPM_SUM_CHANNEL_DECODER_TOP_DEFINES_SVH
`define PPM_SUM_CHANNEL_DECODER_TOP_DEFINES_SVH

// Same-cycle implication, clocked on i_clk, off during reset.
`define PSD_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, clocked on i_clk, off during reset.
`define PSD_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

### rtl/psd_pkg.sv
// Types and constants of the PPM-sum channel decoder.
// No dependencies; used by the channel interfaces and the top level.
package psd_pkg;

    // Item kinds
    typedef enum logic [1:0] {
        KIND_PULSE = 2'd0,
        KIND_TICK  = 2'd1,
        KIND_READ  = 2'd2,
        KIND_OVR   = 2'd3
    } t_kind;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_MIN_CH     = 2'd0,
        CFG_FS_CH      = 2'd1,
        CFG_FS_TIMEOUT = 2'd2,
        CFG_FS_VALUE   = 2'd3
    } t_cfg_idx;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    localparam int OVR_SLOTS  = 8;

    localparam logic [15:0] SYNC_WIDTH       = 16'd4000;
    localparam logic [3:0]  RST_MIN_CH       = 4'd4;
    localparam logic [2:0]  RST_FS_CH        = 3'd2;
    localparam logic [15:0] RST_FS_TIMEOUT   = 16'd50;
    localparam logic [15:0] RST_FS_VALUE     = 16'd900;

    typedef struct packed {
        t_kind              kind;
        logic [15:0]        pulse_width;
        logic [2:0]         channel;
        logic signed [15:0] override_value;
    } t_in_item;

    typedef struct packed {
        logic [15:0] channel_value;
        logic [3:0]  valid_count;
        logic        override_active;
    } t_out_item;

endpackage

### rtl/psd_if.sv
// Valid/ready channel interfaces for decoder items and results.
// Depends on psd_pkg for the payload types.
interface psd_in_if;
    logic               valid;
    logic               ready;
    psd_pkg::t_in_item  data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

interface psd_out_if;
    logic               valid;
    logic               ready;
    psd_pkg::t_out_item data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

### rtl/ppm_sum_channel_decoder_top.sv
// PPM-sum channel decoder: one registered result per accepted item.
// Throughput: one item per cycle; a one-entry skid behind the result register drops
// ready only while the output is stalled two items deep.
// Reset (i_rst_n low, synchronous) clears counters, uptime, channel and override
// stores, and restores the configuration registers to their defaults.
// Depends on psd_pkg, psd_if and the assertion macro header.
`include "ppm_sum_channel_decoder_top_defines.svh"

module ppm_sum_channel_decoder_top #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [psd_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [psd_pkg::CFG_DATA_W-1:0] i_cfg_wdata,
    psd_in_if.sink                        i_item,
    psd_out_if.source                     o_result
);

    localparam int CNT_W = $clog2(NUM_CHANNELS + 1);
    localparam int IDX_W = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;

    // Configuration registers
    logic [3:0]  r_min_ch;
    logic [2:0]  r_fs_ch;
    logic [15:0] r_fs_timeout;
    logic [15:0] r_fs_value;

    // Decoder state
    logic [CNT_W-1:0] r_slot_cnt, n_slot_cnt;
    logic [CNT_W-1:0] r_pub_cnt,  n_pub_cnt;
    logic [31:0]      r_uptime,   n_uptime;
    logic [15:0]      r_width [NUM_CHANNELS];
    logic [31:0]      r_stamp [NUM_CHANNELS];
    logic [15:0]      r_ovr   [psd_pkg::OVR_SLOTS];

    // Result register and skid entry
    logic               r_out_vld,  n_out_vld;
    logic               r_skid_vld, n_skid_vld;
    psd_pkg::t_out_item r_out_data, n_out_data;
    psd_pkg::t_out_item r_skid_data, n_skid_data;

    logic               acc, take;
    psd_pkg::t_in_item  item;
    psd_pkg::t_out_item res;
    logic               is_sync, slot_wr, ovr_wr;
    logic [IDX_W-1:0]   wr_idx, rd_idx;
    logic [31:0]        ch32, slot32, pub32, age;
    logic               ch_in_range;
    logic [15:0]        rd_width, rd_data, ovr_val;
    logic [31:0]        rd_stamp;

    assign item = i_item.data;
    assign acc  = i_item.valid && i_item.ready;
    assign take = r_out_vld && o_result.ready;

    assign i_item.ready   = !r_skid_vld;
    assign o_result.valid = r_out_vld;
    assign o_result.data  = r_out_data;

    // Write configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_ch     <= psd_pkg::RST_MIN_CH;
            r_fs_ch      <= psd_pkg::RST_FS_CH;
            r_fs_timeout <= psd_pkg::RST_FS_TIMEOUT;
            r_fs_value   <= psd_pkg::RST_FS_VALUE;
        end else if (i_cfg_we) begin
            unique case (psd_pkg::t_cfg_idx'(i_cfg_idx))
                psd_pkg::CFG_MIN_CH:     r_min_ch     <= i_cfg_wdata[3:0];
                psd_pkg::CFG_FS_CH:      r_fs_ch      <= i_cfg_wdata[2:0];
                psd_pkg::CFG_FS_TIMEOUT: r_fs_timeout <= i_cfg_wdata;
                psd_pkg::CFG_FS_VALUE:   r_fs_value   <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    // Decode the item: slot fill, sync, tick and override write
    always_comb begin
        slot32     = 32'(r_slot_cnt);
        is_sync    = item.pulse_width >= psd_pkg::SYNC_WIDTH;
        slot_wr    = acc && (item.kind == psd_pkg::KIND_PULSE) && !is_sync
                     && (slot32 < NUM_CHANNELS);
        ovr_wr     = acc && (item.kind == psd_pkg::KIND_OVR) && !item.override_value[15];
        wr_idx     = r_slot_cnt[IDX_W-1:0];
        n_slot_cnt = r_slot_cnt;
        n_pub_cnt  = r_pub_cnt;
        n_uptime   = r_uptime;
        if (acc && item.kind == psd_pkg::KIND_PULSE && is_sync) begin
            if (slot32 >= 32'(r_min_ch)) begin
                n_pub_cnt = r_slot_cnt;
            end
            n_slot_cnt = '0;
        end else if (slot_wr) begin
            n_slot_cnt = r_slot_cnt + CNT_W'(1);
            if (slot32 + 32'd1 == NUM_CHANNELS) begin
                n_pub_cnt = CNT_W'(NUM_CHANNELS);
            end
        end
        if (acc && item.kind == psd_pkg::KIND_TICK) begin
            n_uptime = r_uptime + 32'd1;
        end
    end

    // Read path: stored width, then failsafe, then override
    always_comb begin
        ch32        = 32'(item.channel);
        rd_idx      = ch32[IDX_W-1:0];
        ch_in_range = ch32 < NUM_CHANNELS;
        rd_width    = ch_in_range ? r_width[rd_idx] : 16'd0;
        rd_stamp    = ch_in_range ? r_stamp[rd_idx] : 32'd0;
        age         = r_uptime - rd_stamp;
        ovr_val     = r_ovr[item.channel];
        rd_data     = rd_width;
        if (item.channel == r_fs_ch && age > 32'(r_fs_timeout)) begin
            rd_data = r_fs_value;
        end
        if (ovr_val != 16'd0) begin
            rd_data = ovr_val;
        end
    end

    // Form the result item
    always_comb begin
        pub32               = 32'(n_pub_cnt);
        res.channel_value   = (item.kind == psd_pkg::KIND_READ) ? rd_data : 16'd0;
        res.valid_count     = pub32[3:0];
        res.override_active = (item.kind == psd_pkg::KIND_OVR)
                              && !item.override_value[15]
                              && (item.override_value != 16'sd0);
    end

    // Advance decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot_cnt <= '0;
            r_pub_cnt  <= '0;
            r_uptime   <= '0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_width[i] <= '0;
                r_stamp[i] <= '0;
            end
            for (int i = 0; i < psd_pkg::OVR_SLOTS; i++) begin
                r_ovr[i] <= '0;
            end
        end else begin
            r_slot_cnt <= n_slot_cnt;
            r_pub_cnt  <= n_pub_cnt;
            r_uptime   <= n_uptime;
            if (slot_wr) begin
                r_width[wr_idx] <= item.pulse_width;
                r_stamp[wr_idx] <= r_uptime;
            end
            if (ovr_wr) begin
                r_ovr[item.channel] <= unsigned'(item.override_value);
            end
        end
    end

    // Steer results into the output register or the skid entry
    always_comb begin
        n_out_vld   = r_out_vld;
        n_skid_vld  = r_skid_vld;
        n_out_data  = r_out_data;
        n_skid_data = r_skid_data;
        if (take) begin
            if (r_skid_vld) begin
                n_out_data = r_skid_data;
                n_skid_vld = 1'b0;
            end else begin
                n_out_vld  = acc;
                n_out_data = res;
            end
        end else if (acc) begin
            if (!r_out_vld) begin
                n_out_vld  = 1'b1;
                n_out_data = res;
            end else begin
                n_skid_vld  = 1'b1;
                n_skid_data = res;
            end
        end
    end

    // Hold result handshake state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_vld  <= 1'b0;
            r_skid_vld <= 1'b0;
        end else begin
            r_out_vld  <= n_out_vld;
            r_skid_vld <= n_skid_vld;
        end
    end

    // Result payload needs no reset
    always_ff @(posedge i_clk) begin
        r_out_data  <= n_out_data;
        r_skid_data <= n_skid_data;
    end

    // Checks
    `PSD_ASSERT_NOW(a_skid_behind_out, r_skid_vld, r_out_vld)
    `PSD_ASSERT_NOW(a_slot_range, 1'b1, 32'(r_slot_cnt) <= NUM_CHANNELS)
    `PSD_ASSERT_NOW(a_pub_range, 1'b1, 32'(r_pub_cnt) <= NUM_CHANNELS)
    `PSD_ASSERT_NEXT(a_tick_step, acc && item.kind == psd_pkg::KIND_TICK,
        r_uptime == $past(r_uptime) + 32'd1)
    `PSD_ASSERT_NEXT(a_accept_lands, acc, r_out_vld)

endmodule

### tb/sv/testbench.sv
// Testbench for the PPM-sum channel decoder: random frames, ticks, reads and
// override writes checked item by item against a cycle-free predictor.
// Depends on psd_pkg, psd_if and ppm_sum_channel_decoder_top.
`timescale 1ns / 1ps

module testbench;

    localparam int NUM_CH     = 8;
    localparam int QUIET_MAX  = 2000;
    localparam int PHASE_ITEMS = 235;

    // Predicts each result from the decoder state and checks results in order
    class ppm_frame_predictor;
        bit [3:0]  min_ch;
        bit [2:0]  fs_ch;
        bit [15:0] fs_timeout;
        bit [15:0] fs_value;
        bit [3:0]  slot_cnt;
        bit [3:0]  published;
        bit [15:0] widths [NUM_CH];
        bit [31:0] stamps [NUM_CH];
        bit [31:0] uptime;
        bit [15:0] overrides [psd_pkg::OVR_SLOTS];
        psd_pkg::t_out_item predicted_results [$];
        int        errors;

        function new();
            min_ch     = psd_pkg::RST_MIN_CH;
            fs_ch      = psd_pkg::RST_FS_CH;
            fs_timeout = psd_pkg::RST_FS_TIMEOUT;
            fs_value   = psd_pkg::RST_FS_VALUE;
            slot_cnt   = '0;
            published  = '0;
            uptime     = '0;
            errors     = 0;
            foreach (widths[i]) begin
                widths[i] = '0;
                stamps[i] = '0;
            end
            foreach (overrides[i]) overrides[i] = '0;
        endfunction

        function void set_reg(psd_pkg::t_cfg_idx idx, logic [15:0] wdata);
            case (idx)
                psd_pkg::CFG_MIN_CH:     min_ch     = wdata[3:0];
                psd_pkg::CFG_FS_CH:      fs_ch      = wdata[2:0];
                psd_pkg::CFG_FS_TIMEOUT: fs_timeout = wdata;
                psd_pkg::CFG_FS_VALUE:   fs_value   = wdata;
                default: ;
            endcase
        endfunction

        // Advance the state by one accepted item and queue its result
        function void take_item(psd_pkg::t_in_item it);
            psd_pkg::t_out_item res;
            bit [15:0] rd;
            res = '0;
            case (it.kind)
                psd_pkg::KIND_PULSE: begin
                    if (it.pulse_width >= psd_pkg::SYNC_WIDTH) begin
                        if (slot_cnt >= min_ch) published = slot_cnt;
                        slot_cnt = '0;
                    end else if (slot_cnt < NUM_CH) begin
                        widths[slot_cnt] = it.pulse_width;
                        stamps[slot_cnt] = uptime;
                        slot_cnt = slot_cnt + 1'b1;
                        if (slot_cnt == NUM_CH) published = 4'(NUM_CH);
                    end
                end
                psd_pkg::KIND_TICK: uptime = uptime + 32'd1;
                psd_pkg::KIND_READ: begin
                    rd = widths[it.channel];
                    if (it.channel == fs_ch &&
                        (uptime - stamps[it.channel]) > {16'b0, fs_timeout})
                        rd = fs_value;
                    if (overrides[it.channel] != 0) rd = overrides[it.channel];
                    res.channel_value = rd;
                end
                default: begin
                    // negative override values leave the store untouched
                    if (!it.override_value[15]) begin
                        overrides[it.channel] = it.override_value;
                        res.override_active = (it.override_value != 0);
                    end
                end
            endcase
            res.valid_count = published;
            predicted_results.push_back(res);
        endfunction

        function void match_result(psd_pkg::t_out_item got);
            psd_pkg::t_out_item want;
            if (predicted_results.size() == 0) begin
                $error("result with nothing predicted: value %0d count %0d active %0b",
                       got.channel_value, got.valid_count, got.override_active);
                errors++;
                return;
            end
            want = predicted_results.pop_front();
            if (got.channel_value !== want.channel_value) begin
                $error("channel_value: expected %0d, got %0d",
                       want.channel_value, got.channel_value);
                errors++;
            end
            if (got.valid_count !== want.valid_count) begin
                $error("valid_count: expected %0d, got %0d",
                       want.valid_count, got.valid_count);
                errors++;
            end
            if (got.override_active !== want.override_active) begin
                $error("override_active: expected %0b, got %0b",
                       want.override_active, got.override_active);
                errors++;
            end
        endfunction

        function int pending();
            return predicted_results.size();
        endfunction
    endclass

    logic                           i_clk = 1'b0;
    logic                           i_rst_n;
    logic                           i_cfg_we;
    logic [psd_pkg::CFG_IDX_W-1:0]  i_cfg_idx;
    logic [psd_pkg::CFG_DATA_W-1:0] i_cfg_wdata;

    psd_in_if  item_ch ();
    psd_out_if result_ch ();

    ppm_sum_channel_decoder_top #(
        .NUM_CHANNELS (NUM_CH)
    ) dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .i_item      (item_ch),
        .o_result    (result_ch)
    );

    ppm_frame_predictor book = new();

    bit send_busy;
    bit recv_busy;
    int items_in;
    int frame_left;
    int quiet;

    always #2 i_clk = ~i_clk;

    // Check results and watch for a stalled run
    always @(posedge i_clk) begin
        if (i_rst_n && result_ch.valid && result_ch.ready)
            book.match_result(result_ch.data);
        if ((item_ch.valid && item_ch.ready) || (result_ch.valid && result_ch.ready))
            quiet <= 0;
        else
            quiet <= quiet + 1;
        if (quiet >= QUIET_MAX) begin
            $display("testbench: errors");
            $finish;
        end
    end

    // Drain results with random stalls, and stretches of none
    initial begin
        int stall;
        int served;
        served = 0;
        result_ch.ready <= 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (served % 64 == 0) recv_busy = ($urandom_range(0, 3) == 0);
            stall = recv_busy ? 0 : $urandom_range(0, 14);
            if (stall > 0) begin
                result_ch.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            result_ch.ready <= 1'b1;
            @(posedge i_clk);
            while (!result_ch.valid) @(posedge i_clk);
            served++;
        end
    end

    function automatic psd_pkg::t_in_item junk_item();
        logic [63:0] r;
        r = {$urandom, $urandom};
        return r[$bits(psd_pkg::t_in_item)-1:0];
    endfunction

    function automatic psd_pkg::t_in_item mk(psd_pkg::t_kind kind, logic [15:0] width,
                                             logic [2:0] ch, logic [15:0] ovr);
        psd_pkg::t_in_item it;
        it.kind           = kind;
        it.pulse_width    = width;
        it.channel        = ch;
        it.override_value = ovr;
        return it;
    endfunction

    // Offer one item after a random gap and hold it until accepted
    task automatic send_item(psd_pkg::t_in_item it);
        int gap;
        gap = send_busy ? 0 : $urandom_range(0, 14);
        if (gap > 0) begin
            item_ch.valid <= 1'b0;
            item_ch.data  <= junk_item();
            repeat (gap) @(posedge i_clk);
        end
        item_ch.valid <= 1'b1;
        item_ch.data  <= it;
        @(posedge i_clk);
        while (!item_ch.ready) @(posedge i_clk);
        book.take_item(it);
        items_in++;
    endtask

    // Drop valid and wait until every predicted result has come back
    task automatic settle();
        item_ch.valid <= 1'b0;
        while (book.pending() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic program_reg(psd_pkg::t_cfg_idx idx, logic [15:0] value);
        i_cfg_we    <= 1'b1;
        i_cfg_idx   <= idx;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        book.set_reg(idx, value);
    endtask

    // Write all four registers; narrow ones carry junk in their unused bits
    task automatic program_all(logic [3:0] min_ch, logic [2:0] fs_ch,
                               logic [15:0] tmo, logic [15:0] fs_val);
        logic [15:0] w;
        w = 16'($urandom);
        w[3:0] = min_ch;
        program_reg(psd_pkg::CFG_MIN_CH, w);
        w = 16'($urandom);
        w[2:0] = fs_ch;
        program_reg(psd_pkg::CFG_FS_CH, w);
        program_reg(psd_pkg::CFG_FS_TIMEOUT, tmo);
        program_reg(psd_pkg::CFG_FS_VALUE, fs_val);
        i_cfg_we <= 1'b0;
    endtask

    task automatic directed_items();
        send_item(mk(psd_pkg::KIND_READ, 16'd0, 3'd0, 16'd0));
        send_item(mk(psd_pkg::KIND_READ, 16'd0, 3'd2, 16'd0));
        // short frame below the minimum, then a sync that publishes four
        send_item(mk(psd_pkg::KIND_PULSE, 16'd4000, 3'd0, 16'd0));
        send_item(mk(psd_pkg::KIND_PULSE, 16'd0, 3'd0, 16'd0));
        send_item(mk(psd_pkg::KIND_PULSE, 16'd3999, 3'd0, 16'd0));
        send_item(mk(psd_pkg::KIND_PULSE, 16'd1000, 3'd0, 16'd0));
        send_item(mk(psd_pkg::KIND_PULSE, 16'd2000, 3'd0, 16'd0));
        send_item(mk(psd_pkg::KIND_PULSE, 16'hFFFF, 3'd0, 16'd0));
        // full frame publishes all channels, the extra pulse is ignored
        for (int i = 0; i < NUM_CH + 1; i++)
            send_item(mk(psd_pkg::KIND_PULSE, 16'd1100 + 16'(i * 100), 3'd0, 16'd0));
        send_item(mk(psd_pkg::KIND_PULSE, 16'd4000, 3'd0, 16'd0));
        send_item(mk(psd_pkg::KIND_TICK, 16'd0, 3'd0, 16'd0));
        // override: negative is ignored, positive sets, zero clears
        send_item(mk(psd_pkg::KIND_OVR, 16'd0, 3'd7, 16'h8000));
        send_item(mk(psd_pkg::KIND_OVR, 16'd0, 3'd7, 16'hFFFF));
        send_item(mk(psd_pkg::KIND_OVR, 16'd0, 3'd7, 16'h7FFF));
        send_item(mk(psd_pkg::KIND_READ, 16'd0, 3'd7, 16'd0));
        send_item(mk(psd_pkg::KIND_OVR, 16'd0, 3'd7, 16'h0000));
        send_item(mk(psd_pkg::KIND_READ, 16'd0, 3'd7, 16'd0));
        send_item(mk(psd_pkg::KIND_READ, 16'd0, 3'd2, 16'd0));
    endtask

    // Mostly well-formed frames mixed with ticks, reads, overrides and noise
    task automatic random_items(int target);
        psd_pkg::t_in_item it;
        int r;
        int burst;
        while (items_in < target) begin
            if (items_in % 100 == 0) send_busy = ($urandom_range(0, 3) == 0);
            it = junk_item();
            r  = $urandom_range(0, 99);
            if (r < 10) begin
                send_item(it);
            end else if (r < 55) begin
                it.kind = psd_pkg::KIND_PULSE;
                if (frame_left == 0) begin
                    it.pulse_width = $urandom_range(0, 1) ? 16'($urandom_range(4000, 4100))
                                                          : 16'($urandom_range(4000, 65535));
                    r = $urandom_range(0, 9);
                    frame_left = (r < 6) ? NUM_CH :
                                 (r == 6) ? $urandom_range(NUM_CH + 1, NUM_CH + 2) :
                                 $urandom_range(0, NUM_CH - 1);
                end else begin
                    it.pulse_width = $urandom_range(0, 3) ? 16'($urandom_range(900, 2100))
                                                          : 16'($urandom_range(0, 3999));
                    frame_left--;
                end
                send_item(it);
            end else if (r < 70) begin
                burst = ($urandom_range(0, 7) == 0) ? $urandom_range(20, 70) : 1;
                repeat (burst) begin
                    it = junk_item();
                    it.kind = psd_pkg::KIND_TICK;
                    send_item(it);
                end
            end else if (r < 88) begin
                it.kind = psd_pkg::KIND_READ;
                if ($urandom_range(0, 2) == 0) it.channel = book.fs_ch;
                send_item(it);
            end else begin
                it.kind = psd_pkg::KIND_OVR;
                r = $urandom_range(0, 5);
                if (r < 2) it.override_value[15] = 1'b1;
                else if (r == 2) it.override_value = '0;
                else it.override_value[15] = 1'b0;
                send_item(it);
            end
        end
    endtask

    // Reset, directed items, then random phases under several settings
    initial begin
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= psd_pkg::CFG_MIN_CH;
        i_cfg_wdata   <= '0;
        item_ch.valid <= 1'b0;
        item_ch.data  <= '0;
        items_in      = 0;
        frame_left    = 0;
        send_busy     = 1'b0;
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        directed_items();
        random_items(items_in + PHASE_ITEMS);
        settle();

        program_all(4'd0, 3'd0, 16'd0, 16'd0);
        random_items(items_in + PHASE_ITEMS);
        settle();

        program_all(4'd8, 3'd7, 16'hFFFF, 16'hFFFF);
        random_items(items_in + PHASE_ITEMS);
        settle();

        // minimum above the frame size: only full frames publish
        program_all(4'd12, 3'd3, 16'd5, 16'd1500);
        random_items(items_in + PHASE_ITEMS);
        settle();

        repeat (3) begin
            program_all(4'($urandom_range(0, NUM_CH)), 3'($urandom_range(0, 7)),
                        16'($urandom_range(0, 120)), 16'($urandom));
            random_items(items_in + PHASE_ITEMS);
            settle();
        end

        if (book.errors == 0 && book.pending() == 0)
            $display("testbench: clean");
        else
            $display("testbench: errors");
        $finish;
    end

endmodule
